>>> design/pctl_pkg.sv
// ---------------------------------------------------------------------------
// pctl_pkg: shared types and constants for the profile coefficient lookup
// Row layout, divider request/response, sequencer states and helpers.
// ---------------------------------------------------------------------------
package pctl_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int IN_DW  = 104;
  localparam int OUT_DW = 32;

  // divider and accumulator widths
  localparam int ACC_W  = 60;
  localparam int DIV_NW = 60;
  localparam int DIV_DW = 43;
  localparam int DIV_QW = 35;
  localparam int DIV_KW = 6;

  // register indexes of the configuration port
  typedef enum logic [CFG_AW-1:0] {
    CFG_USE_RE_MACH    = 3'd0,
    CFG_ROW_COUNT      = 3'd1,
    CFG_ANGLE_RANGE    = 3'd2,
    CFG_REYNOLDS_RANGE = 3'd3,
    CFG_MACH_RANGE     = 3'd4
  } cfg_idx_t;

  // one table row as held in the memory
  typedef struct packed {
    logic signed [15:0] lift;
    logic signed [15:0] drag;
    logic        [15:0] mach;
    logic        [31:0] reynolds;
    logic signed [15:0] angle;
  } row_t;

  typedef struct packed {
    logic              start;
    logic [DIV_KW-1:0] qbits;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LIN, S_LMUL, S_WROW, S_NORM, S_NWAIT, S_SQ,
    S_WSTART, S_WWAIT, S_MD, S_AD, S_AL, S_FSTART, S_FWAIT, S_OUT
  } state_t;

  // clip to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767)       r = 16'sh7fff;
    else if (v < -19'sd32768) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

endpackage

>>> design/pctl_mem.sv
// ---------------------------------------------------------------------------
// pctl_mem: profile table memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pctl_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  pctl_pkg::row_t   wdata,
  input  logic [AW-1:0]    raddr,
  output pctl_pkg::row_t   rdata
);
  import pctl_pkg::*;

  row_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/pctl_div.sv
// ---------------------------------------------------------------------------
// pctl_div: shared restoring divider
// One quotient bit per cycle; caller ensures num < den << qbits.
// ---------------------------------------------------------------------------
module pctl_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pctl_pkg::div_req_t  req,
  output pctl_pkg::div_rsp_t  rsp
);
  import pctl_pkg::*;

  localparam int SH_W = DIV_DW + DIV_QW;

  logic              busy_r;
  logic              done_r;
  logic [DIV_NW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_KW-1:0] k_r;
  logic [DIV_QW-1:0] quot_r;
  logic [SH_W-1:0]   sh;
  logic              ge;

  // divisor aligned to the current quotient bit
  assign sh = {{DIV_QW{1'b0}}, den_r} << k_r;
  assign ge = {{(SH_W-DIV_NW){1'b0}}, rem_r} >= sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && k_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      den_r  <= req.den;
      k_r    <= req.qbits - 1'b1;
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r     <= rem_r - sh[DIV_NW-1:0];
        quot_r[k_r] <= 1'b1;
      end
      if (k_r != '0) begin
        k_r <= k_r - 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

>>> design/profile_coefficient_table_lookup_top.sv
// ---------------------------------------------------------------------------
// profile_coefficient_table_lookup_top: wing profile table with lookup
// Loads table rows and answers coefficient queries by interpolation or
// inverse-distance weighting.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tuser is the command (0 load row, 1 query).
//           A load is written to the table memory on acceptance and gives
//           no result. A query gives exactly one result on out_*.
//   out_* : drag and lift in tdata, status (table empty) in tuser.
//   cfg_* : register writes, only while the block is idle.
// Lookup: a query in interpolation mode scans the rows and, when the point
//   lies between two rows, runs two 17-bit divisions. In weighting mode
//   each row takes up to three 16-bit and one 35-bit division through the
//   one-bit-per-cycle divider, and two final divides follow the last row.
//   The shared divider sets the query time; one request is worked at a time.
// Reset: clears control state and configuration registers to defaults;
//   table contents stay undefined until loaded, so no clearing pass is run.
// Stall: a finished result sits in the output register; loads are still
//   taken while it waits. A further query is taken and worked, then its
//   result waits and the input is held off until the register frees.
// ---------------------------------------------------------------------------
module profile_coefficient_table_lookup_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // row_index[7:0], angle[23:8], reynolds[55:24], mach[71:56],
  // drag_in[87:72], lift_in[103:88]
  input  logic [pctl_pkg::IN_DW-1:0]   in_tdata,
  // cmd[0]
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // drag_out[15:0], lift_out[31:16]
  output logic [pctl_pkg::OUT_DW-1:0]  out_tdata,
  // status[0]
  output logic                         out_tuser,
  input  logic                         cfg_we,
  input  logic [pctl_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [pctl_pkg::CFG_DW-1:0]  cfg_wdata
);
  import pctl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // configuration registers
  logic        use_re_mach_r;
  logic [8:0]  row_count_r;
  logic [15:0] angle_range_r;
  logic [31:0] reynolds_range_r;
  logic [15:0] mach_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_re_mach_r    <= 1'b0;
      row_count_r      <= '0;
      angle_range_r    <= 16'd1;
      reynolds_range_r <= 32'd1;
      mach_range_r     <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_USE_RE_MACH:    use_re_mach_r    <= cfg_wdata[0];
        CFG_ROW_COUNT:      row_count_r      <= cfg_wdata[8:0];
        CFG_ANGLE_RANGE:    angle_range_r    <= cfg_wdata[15:0];
        CFG_REYNOLDS_RANGE: reynolds_range_r <= cfg_wdata;
        CFG_MACH_RANGE:     mach_range_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  logic [7:0] in_row_index;
  row_t       in_row;
  assign in_row_index    = in_tdata[7:0];
  assign in_row.angle    = in_tdata[23:8];
  assign in_row.reynolds = in_tdata[55:24];
  assign in_row.mach     = in_tdata[71:56];
  assign in_row.drag     = in_tdata[87:72];
  assign in_row.lift     = in_tdata[103:88];

  state_t state_r, state_nxt;
  logic   acc;
  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  // request registers
  logic               mode_r;
  logic signed [15:0] x_r;
  logic [31:0]        re_r;
  logic [15:0]        ma_r;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      idx_r;
  row_t               prev_r, cur_r, rd;
  logic [15:0]        nv_r [3];
  logic [1:0]         ph_r;
  logic [33:0]        d2_r;
  logic [DIV_QW-1:0]  w_r;
  logic signed [ACC_W-1:0] prod_r, sd_r, sl_r;
  logic [DIV_DW-1:0]  sw_r;
  logic               sel_r;
  logic signed [15:0] res_drag_r, res_lift_r;
  logic               res_status_r;
  logic               out_tvalid_r, out_status_r;
  logic [OUT_DW-1:0]  out_data_r;

  // table memory
  logic mem_we;
  assign mem_we = acc && !in_tuser && (13'(in_row_index) < 13'(TABLE_DEPTH));

  pctl_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_row_index)),
    .wdata (in_row),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  pctl_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // clipped row count
  logic [CW-1:0] n_eff;
  assign n_eff = ({4'b0, row_count_r} > 13'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                         : CW'(row_count_r);

  logic last;
  assign last = (CW'(idx_r + 1'b1) == n_r);

  // interpolation terms
  logic signed [16:0] dx, span, diff;
  logic signed [33:0] lmul;
  assign dx   = {x_r[15], x_r} - {prev_r.angle[15], prev_r.angle};
  assign span = {cur_r.angle[15], cur_r.angle} - {prev_r.angle[15], prev_r.angle};
  assign diff = sel_r ? ({cur_r.lift[15], cur_r.lift} - {prev_r.lift[15], prev_r.lift})
                      : ({cur_r.drag[15], cur_r.drag} - {prev_r.drag[15], prev_r.drag});
  assign lmul = dx * diff;

  // normalised distance operands for the current dimension
  logic signed [16:0] ad;
  logic [15:0]        ad_abs, md_abs;
  logic [31:0]        nd, nrng, rd_abs;
  logic               nsat;
  assign ad     = {x_r[15], x_r} - {cur_r.angle[15], cur_r.angle};
  assign ad_abs = ad[16] ? 16'(-ad) : ad[15:0];
  assign rd_abs = (re_r >= cur_r.reynolds) ? re_r - cur_r.reynolds : cur_r.reynolds - re_r;
  assign md_abs = (ma_r >= cur_r.mach) ? ma_r - cur_r.mach : cur_r.mach - ma_r;

  always_comb begin
    case (ph_r)
      2'd0: begin
        nd   = {16'b0, ad_abs};
        nrng = (angle_range_r == '0) ? 32'd1 : {16'b0, angle_range_r};
      end
      2'd1: begin
        nd   = rd_abs;
        nrng = (reynolds_range_r == '0) ? 32'd1 : reynolds_range_r;
      end
      default: begin
        nd   = {16'b0, md_abs};
        nrng = (mach_range_r == '0) ? 32'd1 : {16'b0, mach_range_r};
      end
    endcase
  end
  // quotient would not fit 16 bits: distance at least 16 ranges
  assign nsat = ({4'b0, nd} >= {nrng, 4'b0});

  // weight product
  logic signed [51:0] wmul;
  logic signed [15:0] wcoef;
  assign wcoef = (state_r == S_MD) ? cur_r.drag : cur_r.lift;
  assign wmul  = $signed({1'b0, w_r}) * wcoef;

  logic [31:0] nsq;
  assign nsq = nv_r[ph_r] * nv_r[ph_r];

  // final rounding divide
  logic signed [ACC_W-1:0] fnum;
  logic [ACC_W-1:0]        fmag;
  logic [DIV_DW-1:0]       fden;
  logic                    fneg;
  logic signed [18:0]      fq, fbase;
  logic signed [15:0]      fres;
  assign fnum  = mode_r ? (sel_r ? sl_r : sd_r) : prod_r;
  assign fneg  = fnum[ACC_W-1];
  assign fmag  = fneg ? ACC_W'(-fnum) : ACC_W'(fnum);
  assign fden  = mode_r ? sw_r : {{(DIV_DW-16){1'b0}}, span[15:0]};
  assign fq    = fneg ? -$signed({2'b0, drsp.quot[16:0]}) : $signed({2'b0, drsp.quot[16:0]});
  assign fbase = mode_r ? 19'sd0
                        : (sel_r ? 19'(prev_r.lift) : 19'(prev_r.drag));
  assign fres  = sat16(fbase + fq);

  // next state and divider requests
  always_comb begin
    state_nxt  = state_r;
    dreq.start = 1'b0;
    dreq.qbits = 6'd17;
    dreq.num   = DIV_NW'(fmag) + DIV_NW'(fden >> 1);
    dreq.den   = fden;
    unique case (state_r)
      S_IDLE:  if (acc && in_tuser) state_nxt = (n_eff == '0) ? S_OUT : S_RD;
      S_RD:    state_nxt = mode_r ? S_WROW : S_LIN;
      S_LIN: begin
        if (rd.angle >= x_r)  state_nxt = (idx_r == '0) ? S_OUT : S_LMUL;
        else                  state_nxt = last ? S_OUT : S_RD;
      end
      S_LMUL:  state_nxt = S_FSTART;
      S_WROW:  state_nxt = S_NORM;
      S_NORM: begin
        if (!nsat) begin
          dreq.start = 1'b1;
          dreq.qbits = 6'd16;
          dreq.num   = {16'b0, nd, 12'b0};
          dreq.den   = {11'b0, nrng};
          state_nxt  = S_NWAIT;
        end else if (ph_r == 2'd2) begin
          state_nxt = S_SQ;
        end
      end
      S_NWAIT: if (drsp.done) state_nxt = (ph_r == 2'd2) ? S_SQ : S_NORM;
      S_SQ:    if (ph_r == 2'd2) state_nxt = S_WSTART;
      S_WSTART: begin
        dreq.start = 1'b1;
        dreq.qbits = 6'd35;
        dreq.num   = DIV_NW'(1) << 34;
        dreq.den   = (d2_r == '0) ? DIV_DW'(1) : DIV_DW'(d2_r);
        state_nxt  = S_WWAIT;
      end
      S_WWAIT: if (drsp.done) state_nxt = S_MD;
      S_MD:    state_nxt = S_AD;
      S_AD:    state_nxt = S_AL;
      S_AL:    state_nxt = last ? S_FSTART : S_RD;
      S_FSTART: begin
        dreq.start = 1'b1;
        state_nxt  = S_FWAIT;
      end
      S_FWAIT: begin
        if (drsp.done) begin
          if (!sel_r) state_nxt = mode_r ? S_FSTART : S_LMUL;
          else        state_nxt = S_OUT;
        end
      end
      S_OUT:   if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (acc && in_tuser) begin
          mode_r       <= use_re_mach_r;
          x_r          <= in_row.angle;
          re_r         <= in_row.reynolds;
          ma_r         <= in_row.mach;
          n_r          <= n_eff;
          idx_r        <= '0;
          sd_r         <= '0;
          sl_r         <= '0;
          sw_r         <= '0;
          sel_r        <= 1'b0;
          res_drag_r   <= '0;
          res_lift_r   <= '0;
          res_status_r <= (n_eff == '0);
        end
      end
      S_LIN: begin
        if (rd.angle >= x_r) begin
          if (idx_r == '0) begin
            res_drag_r <= rd.drag;
            res_lift_r <= rd.lift;
          end
          cur_r <= rd;
        end else if (last) begin
          res_drag_r <= rd.drag;
          res_lift_r <= rd.lift;
        end else begin
          prev_r <= rd;
          idx_r  <= idx_r + 1'b1;
        end
      end
      S_LMUL: prod_r <= ACC_W'(lmul);
      S_WROW: begin
        cur_r <= rd;
        ph_r  <= 2'd0;
      end
      S_NORM: begin
        if (nsat) begin
          nv_r[ph_r] <= 16'hffff;
          ph_r       <= (ph_r == 2'd2) ? 2'd0 : ph_r + 1'b1;
          d2_r       <= '0;
        end
      end
      S_NWAIT: begin
        if (drsp.done) begin
          nv_r[ph_r] <= drsp.quot[15:0];
          ph_r       <= (ph_r == 2'd2) ? 2'd0 : ph_r + 1'b1;
          d2_r       <= '0;
        end
      end
      S_SQ: begin
        d2_r <= d2_r + 34'(nsq);
        ph_r <= ph_r + 1'b1;
      end
      S_WWAIT: if (drsp.done) w_r <= drsp.quot;
      S_MD:    prod_r <= ACC_W'(wmul);
      S_AD: begin
        sd_r   <= sd_r + prod_r;
        prod_r <= ACC_W'(wmul);
      end
      S_AL: begin
        sl_r <= sl_r + prod_r;
        sw_r <= sw_r + DIV_DW'(w_r);
        if (!last) idx_r <= idx_r + 1'b1;
      end
      S_FWAIT: begin
        if (drsp.done) begin
          if (!sel_r) res_drag_r <= fres;
          else        res_lift_r <= fres;
          sel_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
      out_data_r   <= {res_lift_r, res_drag_r};
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

>>> design/pctl_chk.sv
// ---------------------------------------------------------------------------
// pctl_chk: port-level checks for the profile coefficient lookup
// Watches the request and result streams; bound to the top level.
// ---------------------------------------------------------------------------
module pctl_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [pctl_pkg::IN_DW-1:0]   in_tdata,
  input logic                         in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [pctl_pkg::OUT_DW-1:0]  out_tdata,
  input logic                         out_tuser
);
  import pctl_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // empty-table result carries zero coefficients
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("empty-table result not zero");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("result after a load request");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("request taken while a query is in progress");

endmodule

bind profile_coefficient_table_lookup_top pctl_chk u_pctl_chk (.*);

>>> tb/tb_profile_coefficient_table_lookup_top.sv
// ---------------------------------------------------------------------------
// tb_profile_coefficient_table_lookup_top: self-checking bench for the
// profile coefficient lookup.
// Loads the full table, then runs directed and random phases of loads and
// queries in both lookup modes. Every query is predicted in the bench and
// each result is compared field by field, with random stalls on both streams.
// ---------------------------------------------------------------------------
module tb_profile_coefficient_table_lookup_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pctl_pkg::*;

  localparam bit CMD_LOAD  = 1'b0;
  localparam bit CMD_QUERY = 1'b1;
  localparam int DEPTH     = 256;
  localparam int N_ITEMS   = 1400;
  localparam int QUIET_AT  = 1200;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    logic signed [15:0] drag;
    logic signed [15:0] lift;
    logic               status;
  } coef_t;

  // table copy, register copy and the queue of expected coefficients
  class coef_scoreboard;
    logic signed [15:0] ang[DEPTH];
    logic        [31:0] rey[DEPTH];
    logic        [15:0] mch[DEPTH];
    logic signed [15:0] drg[DEPTH];
    logic signed [15:0] lft[DEPTH];
    bit                 weighted;
    int unsigned        rows;
    longint unsigned    a_rng, r_rng, m_rng;
    coef_t              coef_q[$];
    int                 errors, results, loads, queries, empties;

    function new();
      weighted = 0; rows = 0; a_rng = 1; r_rng = 1; m_rng = 1;
      errors = 0; results = 0; loads = 0; queries = 0; empties = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_USE_RE_MACH:    weighted = v[0];
        CFG_ROW_COUNT:      rows = v[8:0];
        CFG_ANGLE_RANGE:    a_rng = v[15:0];
        CFG_REYNOLDS_RANGE: r_rng = v;
        CFG_MACH_RANGE:     m_rng = v[15:0];
        default: ;
      endcase
    endfunction

    // rounds to nearest, halves away from zero; den > 0
    function longint round_div(longint num, longint den);
      longint unsigned m, q;
      m = (num < 0) ? -num : num;
      q = (m + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned norm(longint a, longint b, longint unsigned rng);
      longint unsigned d, n;
      d = (a > b) ? a - b : b - a;
      if (rng == 0) rng = 1;
      n = (d << 12) / rng;
      return (n > 65535) ? 65535 : n;
    endfunction

    function logic signed [15:0] clip(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function void note(logic cmd, logic [IN_DW-1:0] d);
      logic [7:0]  idx;
      longint      x, re, ma, cd, cl, dx, span, sw, sd, sl, w;
      longint unsigned na, nr, nm, d2;
      int unsigned n, i1, i2;
      coef_t       c;
      idx = d[7:0];
      x   = $signed(d[23:8]);
      re  = d[55:24];
      ma  = d[71:56];
      if (cmd == CMD_LOAD) begin
        ang[idx] = d[23:8]; rey[idx] = d[55:24]; mch[idx] = d[71:56];
        drg[idx] = d[87:72]; lft[idx] = d[103:88];
        loads++;
        return;
      end
      queries++;
      n = (rows > DEPTH) ? DEPTH : rows;
      c.status = 0; cd = 0; cl = 0;
      if (n == 0) begin
        c.status = 1;
        empties++;
      end else if (weighted) begin
        sw = 0; sd = 0; sl = 0;
        for (int i = 0; i < n; i++) begin
          na = norm(x, longint'(ang[i]), a_rng);
          nr = norm(re, longint'(rey[i]), r_rng);
          nm = norm(ma, longint'(mch[i]), m_rng);
          d2 = na * na + nr * nr + nm * nm;
          if (d2 == 0) d2 = 1;
          w = (64'd1 << 34) / d2;
          sw += w; sd += w * drg[i]; sl += w * lft[i];
        end
        cd = round_div(sd, sw);
        cl = round_div(sl, sw);
      end else if (n == 1) begin
        cd = drg[0]; cl = lft[0];
      end else begin
        i2 = 0;
        while (i2 < n && longint'(ang[i2]) < x) i2++;
        if (i2 == 0 || i2 == n) begin
          i1 = (i2 == 0) ? 0 : n - 1;
          cd = drg[i1]; cl = lft[i1];
        end else begin
          i1 = i2 - 1;
          dx = x - ang[i1];
          span = longint'(ang[i2]) - ang[i1];
          cd = drg[i1] + round_div(dx * (longint'(drg[i2]) - drg[i1]), span);
          cl = lft[i1] + round_div(dx * (longint'(lft[i2]) - lft[i1]), span);
        end
      end
      c.drag = clip(cd);
      c.lift = clip(cl);
      coef_q.push_back(c);
    endfunction

    function void check(logic [OUT_DW-1:0] d, logic st);
      coef_t e;
      results++;
      if (coef_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result drag=%0d lift=%0d status=%0b",
                                   $signed(d[15:0]), $signed(d[31:16]), st);
        return;
      end
      e = coef_q.pop_front();
      if (d[15:0] !== e.drag || d[31:16] !== e.lift || st !== e.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp drag=%0d lift=%0d status=%0b, got drag=%0d lift=%0d status=%0b",
                   e.drag, e.lift, e.status, $signed(d[15:0]), $signed(d[31:16]), st);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  coef_scoreboard sb = new();
  bit     quiet = 0;
  bit     hold_go = 0;
  bit     hold_on = 0;
  int     rx_gap = 0;
  int     sent = 0;
  int     phases = 0;
  longint cycles = 0;

  profile_coefficient_table_lookup_top dut (.*);

  always #1 clk = ~clk;

  // monitor both handshakes at the rising edge; also the run limit
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_tvalid && in_tready) sb.note(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side back-pressure: random bursts, plus the long hold
  always @(negedge clk) begin
    if (hold_on) out_tready = 1'b0;
    else if (rx_gap > 0) begin
      out_tready = 1'b0;
      rx_gap--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_tready = 1'b0;
      rx_gap = $urandom_range(0, 9);
    end else out_tready = 1'b1;
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    @(posedge hold_go);
    hold_on = 1;
    repeat (400) @(negedge clk);
    hold_on = 0;
  end

  function automatic logic [IN_DW-1:0] pack_row(logic [7:0] idx, logic [15:0] a,
                                                logic [31:0] r, logic [15:0] m,
                                                logic [15:0] dg, logic [15:0] lf);
    return {lf, dg, m, r, a, idx};
  endfunction

  // called at a falling edge; returns at a falling edge with valid low
  task automatic send_item(bit cmd, logic [IN_DW-1:0] d);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    sent++;
    if (sent >= QUIET_AT) quiet = 1;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we = 1'b1; cfg_addr = idx; cfg_wdata = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // all results in, then a short pause for a trailing load
  task automatic wait_idle();
    while (sb.coef_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_all(bit wt, int unsigned n, logic [15:0] ar, logic [31:0] rr,
                         logic [15:0] mr);
    wait_idle();
    write_reg(CFG_USE_RE_MACH, wt);
    write_reg(CFG_ROW_COUNT, n);
    write_reg(CFG_ANGLE_RANGE, ar);
    write_reg(CFG_REYNOLDS_RANGE, rr);
    write_reg(CFG_MACH_RANGE, mr);
    phases++;
  endtask

  // ascending spacing of the angle column
  function automatic logic [15:0] base_angle(int i);
    return 16'(-32768 + i * 257);
  endfunction

  task automatic send_query(logic [15:0] a, logic [31:0] r, logic [15:0] m);
    send_item(CMD_QUERY, pack_row(8'($urandom), a, r, m, 16'($urandom), 16'($urandom)));
  endtask

  // query near the table or anywhere in the field ranges
  task automatic random_query(int unsigned n);
    int k;
    logic [15:0] a, m;
    logic [31:0] r;
    k = $urandom_range(0, (n == 0 ? 1 : (n > DEPTH ? DEPTH : n)) - 1);
    case ($urandom_range(0, 4))
      0: begin a = 16'($urandom); r = $urandom; m = 16'($urandom); end
      1: begin a = sb.ang[k]; r = sb.rey[k]; m = sb.mch[k]; end
      2: begin
        a = sb.ang[k] + 16'($urandom_range(0, 400) - 200);
        r = sb.rey[k] + $urandom_range(0, 2000) - 1000;
        m = sb.mch[k] + 16'($urandom_range(0, 400) - 200);
      end
      3: begin a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; r = $urandom; m = 16'($urandom); end
      default: begin
        a = sb.ang[k] + 16'($urandom_range(0, 256)); r = sb.rey[k]; m = 16'($urandom);
      end
    endcase
    send_query(a, r, m);
  endtask

  // reload a row, mostly keeping the angle column ascending
  task automatic random_load();
    logic [7:0]  idx;
    logic [15:0] a;
    idx = 8'($urandom);
    if ($urandom_range(0, 19) == 0) a = 16'($urandom);
    else a = base_angle(idx) + 16'($urandom_range(0, 120));
    send_item(CMD_LOAD, pack_row(idx, a, $urandom, 16'($urandom), 16'($urandom),
                                 16'($urandom)));
  endtask

  function automatic logic [31:0] pick_range(int w);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return (w == 32) ? 32'hffffffff : 32'h0000ffff;
      default: return (w == 32) ? $urandom : $urandom_range(1, 65535);
    endcase
  endfunction

  task automatic random_phase();
    bit          wt;
    int unsigned n;
    int          items;
    wt = 1'($urandom_range(0, 1));
    if (wt) n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
    else case ($urandom_range(0, 5))
      0: n = 0;
      1: n = 1;
      2: n = $urandom_range(257, 511);
      default: n = $urandom_range(2, 256);
    endcase
    set_all(wt, n, pick_range(16), pick_range(32), pick_range(16));
    items = $urandom_range(20, 40);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 9) < 3) random_load();
      else random_query(n);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty table straight after reset
    send_query(16'h0000, 32'd0, 16'd0);

    // full table, ascending angles, coefficient extremes on the first rows
    for (int i = 0; i < DEPTH; i++) begin
      logic [15:0] dg, lf;
      dg = (i % 2 == 0) ? 16'h7fff : 16'h8000;
      lf = (i % 2 == 0) ? 16'h8000 : 16'h7fff;
      if (i >= 4) begin dg = 16'($urandom); lf = 16'($urandom); end
      send_item(CMD_LOAD, pack_row(8'(i), base_angle(i),
                (i == 0) ? 32'd0 : (i == 1 ? 32'hffffffff : $urandom),
                (i == 0) ? 16'd0 : (i == 1 ? 16'hffff : 16'($urandom)), dg, lf));
    end

    // interpolation over an oversized row count: clamps, exact rows, midpoints
    set_all(0, 511, 16'hffff, 32'hffffffff, 16'hffff);
    send_query(16'h8000, 0, 0);
    send_query(16'h7fff, 0, 0);
    send_query(16'h8000 + 16'd128, 0, 0);
    send_query(base_angle(100), 0, 0);
    send_query(base_angle(100) + 16'd1, 0, 0);

    // single row, then partial table clamped at its end row
    set_all(0, 1, 1, 1, 1);
    send_query(16'h7fff, 0, 0);
    set_all(0, 3, 1, 1, 1);
    send_query(16'h7fff, 0, 0);
    send_query(base_angle(0) + 16'd100, 0, 0);

    // weighting with zero ranges, exact hit on a row, full ranges, full table
    set_all(1, 2, 0, 0, 0);
    send_query(base_angle(1), sb.rey[1], sb.mch[1]);
    send_query(16'h0000, 32'h80000000, 16'h8000);
    set_all(1, 4, 16'hffff, 32'hffffffff, 16'hffff);
    send_query(base_angle(0), 0, 0);
    send_query(16'h7fff, 32'hffffffff, 16'hffff);
    set_all(1, 256, 16'd1000, 32'd100000, 16'd500);
    send_query(base_angle(50), sb.rey[50], sb.mch[50]);

    // empty table again by register
    set_all(0, 0, 1, 1, 1);
    send_query(16'h1234, 32'd5, 16'd6);

    // receiver holds off while queries keep coming
    set_all(0, 16, 1, 1, 1);
    hold_go = 1;
    for (int i = 0; i < 25; i++) random_query(16);

    while (sent < N_ITEMS) random_phase();

    wait_idle();
    repeat (100) @(negedge clk);
    $display("covered %0d loads and %0d queries (%0d on an empty table) over %0d settings",
             sb.loads, sb.queries, sb.empties, phases);
    $display("%0d results checked, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0 && sb.coef_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
